[hdl/smask_pkg.sv]
package smask_pkg;

  // Screen geometry and slat count
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int BLIND_SLATS   = 8;

  // Field widths
  localparam int XW      = 8;
  localparam int YW      = 8;
  localparam int CW      = 13;
  localparam int LW      = 8;
  localparam int IRIS_RW = 9;
  localparam int MODE_W  = 3;
  localparam int FRAC_W  = 12;
  localparam int FULL_COVER = 4096;

  // Config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Luma table
  localparam int LUMA_AW    = XW + YW;
  localparam int LUMA_DEPTH = 1 << LUMA_AW;

  // Iris
  localparam int HOLE_PW = IRIS_RW + CW;
  localparam int HSQ_W   = 2 * IRIS_RW;
  localparam int D2_W    = 2 * XW + 1;

  // Wipe
  localparam int WIPE_EW = $clog2(SCREEN_WIDTH + 1);
  localparam int WIPE_PW = FRAC_W + WIPE_EW;
  localparam int WIPE_CW = (WIPE_EW > XW) ? WIPE_EW : XW;

  // Curtain
  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam int CUR_EW  = $clog2(HALF_H + 1);
  localparam int CUR_PW  = FRAC_W + CUR_EW;
  localparam int SCR_HW  = $clog2(SCREEN_HEIGHT + 1);
  localparam int SCR_CW  = (SCR_HW > YW) ? SCR_HW : YW;

  // Blinds: quotient by reciprocal, exact for 8-bit rows
  localparam int BAND       = SCREEN_HEIGHT / BLIND_SLATS;
  localparam int BAND_SAFE  = (BAND == 0) ? 1 : BAND;
  localparam int BAND_EW    = $clog2(BAND_SAFE + 1);
  localparam int BAND_PW    = FRAC_W + BAND_EW;
  localparam int BLIND_SPAN = BLIND_SLATS * BAND;
  localparam int RECIP_SH   = 16;
  localparam int BAND_RECIP = ((1 << RECIP_SH) + BAND_SAFE - 1) / BAND_SAFE;
  localparam int BQ_PW      = YW + RECIP_SH + 1;
  localparam int BREM_W     = YW + BAND_EW;

  // Dissolve
  localparam int DIS_RND = 128;
  localparam int DIS_SH  = 8;

  // Luma threshold
  localparam int LUMA_MUL = 255;
  localparam int LT_PW    = LW + CW;

  // Triangle teeth
  localparam int TOOTH_PERIOD = 40;
  localparam int TOOTH_RECIP  = ((1 << RECIP_SH) + TOOTH_PERIOD - 1) / TOOTH_PERIOD;
  localparam int TQ_PW        = YW + RECIP_SH;
  localparam int TOOTH_Q_W    = $clog2(255 / TOOTH_PERIOD + 1);
  localparam int TM_W         = $clog2(TOOTH_PERIOD);
  localparam int TRI_A_MUL    = 440;
  localparam int TRI_DENOM    = 1638400;
  localparam int TRI_NW       = 21;
  localparam int TRI_PW       = (TRI_NW + WIPE_EW > 30) ? TRI_NW + WIPE_EW : 30;

  localparam logic [3:0] BAYER [16] = '{4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
                                        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5};

  typedef enum logic [MODE_W-1:0] {
    MODE_IRIS,
    MODE_WIPE,
    MODE_CURTAIN,
    MODE_BLINDS,
    MODE_DISSOLVE,
    MODE_LUMA,
    MODE_TEETH
  } smask_mode_t;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_FOCUS_X,
    REG_FOCUS_Y,
    REG_IRIS_R
  } smask_reg_t;

  localparam logic [XW-1:0]      FOCUS_X_RST = 8'd128;
  localparam logic [YW-1:0]      FOCUS_Y_RST = 8'd152;
  localparam logic [IRIS_RW-1:0] IRIS_R_RST  = 9'd200;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [XW-1:0]      focus_x;
    logic [YW-1:0]      focus_y;
    logic [IRIS_RW-1:0] iris_r;
  } smask_cfg_t;

  // Stage 1 result
  typedef struct packed {
    logic                 cov_zero;
    logic [XW-1:0]        x;
    logic [YW-1:0]        y;
    logic [HOLE_PW-1:0]   hole_prod;
    logic [XW-1:0]        adx;
    logic [YW-1:0]        ady;
    logic                 wipe_hit;
    logic                 curt_hit;
    logic                 dis_hit;
    logic                 blind_span;
    logic [BAND_EW-1:0]   blind_h;
    logic [YW-1:0]        blind_q;
    logic [LW-1:0]        luma_thr;
    logic [TOOTH_Q_W-1:0] tooth_q;
    logic [TRI_NW-1:0]    tri_a;
  } smask_s1_t;

  // Stage 2 result
  typedef struct packed {
    logic              cov_zero;
    logic [XW-1:0]     x;
    logic [HSQ_W-1:0]  hole_sq;
    logic [D2_W-1:0]   d2;
    logic              simple_hit;
    logic [TRI_NW-1:0] tri_n;
  } smask_s2_t;

endpackage

[hdl/smask_prep.sv]
module smask_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smask_pkg::smask_cfg_t         cfg_i,
  input  logic                          in_valid_i,
  input  logic                          in_write_i,
  input  logic [smask_pkg::XW-1:0]      x_i,
  input  logic [smask_pkg::YW-1:0]      y_i,
  input  logic [smask_pkg::CW-1:0]      cov_i,
  input  logic [smask_pkg::LW-1:0]      luma_i,
  output logic                          in_ready_o,
  output logic                          s1_valid_o,
  output smask_pkg::smask_s1_t          s1_o,
  output logic [smask_pkg::LW-1:0]      luma_rd_o,
  input  logic                          s1_ready_i
);

  logic                            adv;
  logic                            s1_valid_r;
  logic                            s1_valid_nxt;
  smask_pkg::smask_s1_t            s1_r;
  smask_pkg::smask_s1_t            s1_nxt;

  logic [smask_pkg::LW-1:0]        luma_mem [smask_pkg::LUMA_DEPTH];
  logic [smask_pkg::LUMA_AW-1:0]   luma_addr;
  logic [smask_pkg::LW-1:0]        luma_rd_r;

  logic [smask_pkg::CW-1:0]        cov_sat;
  logic [smask_pkg::CW-1:0]        cov_inv;
  logic [smask_pkg::WIPE_PW-1:0]   wipe_prod;
  logic [smask_pkg::WIPE_EW-1:0]   wipe_edge;
  logic [smask_pkg::CUR_PW-1:0]    cur_prod;
  logic [smask_pkg::CUR_EW-1:0]    cur_h;
  logic [smask_pkg::BAND_PW-1:0]   band_prod;
  logic [smask_pkg::BQ_PW-1:0]     bq_prod;
  logic [smask_pkg::CW:0]          dis_sum;
  logic [smask_pkg::CW-smask_pkg::DIS_SH:0] dis_level;
  logic [3:0]                      bayer_val;
  logic [smask_pkg::LT_PW-1:0]     lt_prod;
  logic [smask_pkg::TQ_PW-1:0]     tq_prod;

  assign adv        = !s1_valid_r || s1_ready_i;
  assign in_ready_o = adv;
  assign luma_addr  = {y_i, x_i};

  assign cov_sat = (cov_i > smask_pkg::CW'(smask_pkg::FULL_COVER)) ?
                   smask_pkg::CW'(smask_pkg::FULL_COVER) : cov_i;
  assign cov_inv = smask_pkg::CW'(smask_pkg::FULL_COVER) - cov_sat;

  assign wipe_prod = smask_pkg::WIPE_PW'(cov_sat) *
                     smask_pkg::WIPE_PW'(smask_pkg::SCREEN_WIDTH);
  assign wipe_edge = wipe_prod[smask_pkg::WIPE_PW-1:smask_pkg::FRAC_W];

  assign cur_prod = smask_pkg::CUR_PW'(cov_sat) * smask_pkg::CUR_PW'(smask_pkg::HALF_H);
  assign cur_h    = cur_prod[smask_pkg::CUR_PW-1:smask_pkg::FRAC_W];

  assign band_prod = smask_pkg::BAND_PW'(cov_sat) *
                     smask_pkg::BAND_PW'(smask_pkg::BAND_SAFE);
  assign bq_prod   = smask_pkg::BQ_PW'(y_i) * smask_pkg::BQ_PW'(smask_pkg::BAND_RECIP);

  // level = round(16 * c / 4096)
  assign dis_sum   = {1'b0, cov_sat} + (smask_pkg::CW + 1)'(smask_pkg::DIS_RND);
  assign dis_level = dis_sum[smask_pkg::CW:smask_pkg::DIS_SH];
  assign bayer_val = smask_pkg::BAYER[{y_i[1:0], x_i[1:0]}];

  assign lt_prod = smask_pkg::LT_PW'(cov_sat) * smask_pkg::LT_PW'(smask_pkg::LUMA_MUL);
  assign tq_prod = smask_pkg::TQ_PW'(y_i) * smask_pkg::TQ_PW'(smask_pkg::TOOTH_RECIP);

  always_comb begin
    s1_valid_nxt = in_valid_i && !in_write_i;

    s1_nxt.cov_zero  = (cov_sat == '0);
    s1_nxt.x         = x_i;
    s1_nxt.y         = y_i;
    s1_nxt.hole_prod = smask_pkg::HOLE_PW'(cfg_i.iris_r) * smask_pkg::HOLE_PW'(cov_inv);
    s1_nxt.adx       = (x_i >= cfg_i.focus_x) ? x_i - cfg_i.focus_x : cfg_i.focus_x - x_i;
    s1_nxt.ady       = (y_i >= cfg_i.focus_y) ? y_i - cfg_i.focus_y : cfg_i.focus_y - y_i;
    s1_nxt.wipe_hit  = smask_pkg::WIPE_CW'(x_i) < smask_pkg::WIPE_CW'(wipe_edge);
    s1_nxt.curt_hit  = (smask_pkg::SCR_CW'(y_i) < smask_pkg::SCR_CW'(cur_h)) ||
                       (smask_pkg::SCR_CW'(y_i) >= smask_pkg::SCR_CW'(smask_pkg::SCREEN_HEIGHT)
                                                   - smask_pkg::SCR_CW'(cur_h));
    s1_nxt.dis_hit   = (smask_pkg::CW - smask_pkg::DIS_SH + 1)'(bayer_val) < dis_level;
    s1_nxt.blind_span = smask_pkg::SCR_CW'(y_i) < smask_pkg::SCR_CW'(smask_pkg::BLIND_SPAN);
    s1_nxt.blind_h   = band_prod[smask_pkg::BAND_PW-1:smask_pkg::FRAC_W];
    s1_nxt.blind_q   = bq_prod[smask_pkg::RECIP_SH +: smask_pkg::YW];
    s1_nxt.luma_thr  = lt_prod[smask_pkg::FRAC_W +: smask_pkg::LW];
    s1_nxt.tooth_q   = tq_prod[smask_pkg::RECIP_SH +: smask_pkg::TOOTH_Q_W];
    s1_nxt.tri_a     = smask_pkg::TRI_NW'(cov_sat) * smask_pkg::TRI_NW'(smask_pkg::TRI_A_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // Luma table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (adv && in_valid_i && in_write_i) begin
      luma_mem[luma_addr] <= luma_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma_rd_r <= luma_mem[luma_addr];
    end
  end

  assign s1_valid_o = s1_valid_r;
  assign s1_o       = s1_r;
  assign luma_rd_o  = luma_rd_r;

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !s1_valid_r)
    else $error("stage 1 valid after reset");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid_i && in_write_i |=> !s1_valid_r)
    else $error("table write beat entered the pipeline");
`endif

endmodule

[hdl/smask_eval.sv]
module smask_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  smask_pkg::smask_cfg_t     cfg_i,
  input  logic                      s1_valid_i,
  input  smask_pkg::smask_s1_t      s1_i,
  input  logic [smask_pkg::LW-1:0]  luma_rd_i,
  output logic                      s1_ready_o,
  output logic                      s2_valid_o,
  output smask_pkg::smask_s2_t      s2_o,
  input  logic                      s2_ready_i
);

  logic                               adv;
  logic                               s2_valid_r;
  smask_pkg::smask_s2_t               s2_r;
  smask_pkg::smask_s2_t               s2_nxt;

  logic [smask_pkg::IRIS_RW-1:0]      hole;
  logic [smask_pkg::BREM_W-1:0]       blind_base;
  logic [smask_pkg::BREM_W-1:0]       blind_rem;
  logic                               blind_hit;
  logic                               luma_hit;
  logic [smask_pkg::YW-1:0]           tooth_base;
  logic [smask_pkg::YW-1:0]           tooth_full;
  logic [smask_pkg::TM_W-1:0]         tooth_m;
  logic [smask_pkg::TM_W:0]           two_m;
  logic [smask_pkg::TM_W:0]           tooth_abs;
  logic [smask_pkg::TM_W:0]           tooth_s;
  logic [smask_pkg::TRI_NW-1:0]       tri_sub;
  logic [smask_pkg::TRI_NW-1:0]       tri_diff;

  assign adv        = !s2_valid_r || s2_ready_i;
  assign s1_ready_o = adv;

  assign hole = s1_i.hole_prod[smask_pkg::FRAC_W +: smask_pkg::IRIS_RW];

  // Blinds: row within its band from the stage 1 quotient
  assign blind_base = smask_pkg::BREM_W'(s1_i.blind_q) *
                      smask_pkg::BREM_W'(smask_pkg::BAND_SAFE);
  assign blind_rem  = smask_pkg::BREM_W'(s1_i.y) - blind_base;
  assign blind_hit  = (smask_pkg::BAND != 0) && s1_i.blind_span &&
                      (blind_rem < smask_pkg::BREM_W'(s1_i.blind_h));

  assign luma_hit = luma_rd_i < s1_i.luma_thr;

  // Tooth height s = 40 - |2m - 40|, m = y mod 40
  assign tooth_base = smask_pkg::YW'(s1_i.tooth_q) * smask_pkg::YW'(smask_pkg::TOOTH_PERIOD);
  assign tooth_full = s1_i.y - tooth_base;
  assign tooth_m    = tooth_full[smask_pkg::TM_W-1:0];
  assign two_m      = {tooth_m, 1'b0};
  assign tooth_abs  = (two_m >= (smask_pkg::TM_W + 1)'(smask_pkg::TOOTH_PERIOD)) ?
                      two_m - (smask_pkg::TM_W + 1)'(smask_pkg::TOOTH_PERIOD) :
                      (smask_pkg::TM_W + 1)'(smask_pkg::TOOTH_PERIOD) - two_m;
  assign tooth_s    = (smask_pkg::TM_W + 1)'(smask_pkg::TOOTH_PERIOD) - tooth_abs;
  assign tri_sub    = smask_pkg::TRI_NW'(tooth_s) << smask_pkg::FRAC_W;
  assign tri_diff   = s1_i.tri_a - tri_sub;

  always_comb begin
    s2_nxt.cov_zero = s1_i.cov_zero;
    s2_nxt.x        = s1_i.x;
    s2_nxt.hole_sq  = smask_pkg::HSQ_W'(hole) * smask_pkg::HSQ_W'(hole);
    s2_nxt.d2       = smask_pkg::D2_W'(s1_i.adx) * smask_pkg::D2_W'(s1_i.adx) +
                      smask_pkg::D2_W'(s1_i.ady) * smask_pkg::D2_W'(s1_i.ady);

    if (s1_i.tri_a <= tri_sub) begin
      s2_nxt.tri_n = '0;
    end else if (tri_diff > smask_pkg::TRI_NW'(smask_pkg::TRI_DENOM)) begin
      s2_nxt.tri_n = smask_pkg::TRI_NW'(smask_pkg::TRI_DENOM);
    end else begin
      s2_nxt.tri_n = tri_diff;
    end

    unique case (smask_pkg::smask_mode_t'(cfg_i.mode))
      smask_pkg::MODE_WIPE:     s2_nxt.simple_hit = s1_i.wipe_hit;
      smask_pkg::MODE_CURTAIN:  s2_nxt.simple_hit = s1_i.curt_hit;
      smask_pkg::MODE_BLINDS:   s2_nxt.simple_hit = blind_hit;
      smask_pkg::MODE_DISSOLVE: s2_nxt.simple_hit = s1_i.dis_hit;
      smask_pkg::MODE_LUMA:     s2_nxt.simple_hit = luma_hit;
      default:                  s2_nxt.simple_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid_o = s2_valid_r;
  assign s2_o       = s2_r;

`ifndef SYNTH
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_ready_i |=> s2_valid_r && $stable(s2_r))
    else $error("stage 2 lost or changed a stalled item");
`endif

endmodule

[hdl/screen_transition_pixel_mask.sv]
// Screen-wipe pixel mask.
// Input stream (in_*): one beat per pixel query or luma table write. in_tuser
// selects the operation (0 classify, 1 write table byte at row pixel_y, column
// pixel_x). A classify beat yields exactly one out_* beat whose bit 0 says
// whether the pixel is painted black at the given coverage (0..4096, larger
// values saturate). A write beat yields no output beat.
// Config (cfg_*): APB-style, registers mode, focus_x, focus_y, iris_max_radius
// at byte addresses 0, 4, 8, 12; pready is tied high. Write only while idle.
// Timing: three register stages (operand prep and luma read, squares and
// remainders, final compare into the output register). A classify beat passes
// through the stage 1, stage 2 and output registers before out_tvalid rises;
// one beat is taken every clock unless the output stalls. The luma table has a
// separate write port and registered read port, so only a stall holds the input.
// Stalls: each stage holds when full and blocked; empty stages still fill,
// so in_tready only drops when all three stages hold items and out_tready is
// low. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to mode
// iris, focus (128,152), radius 200. The luma table is not cleared.
module screen_transition_pixel_mask (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] pixel_x, [15:8] pixel_y, [28:16] coverage, [36:29] luma_value, [39:37] zero
  input  logic [39:0]                   in_tdata,
  // [0] operation
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] covered, [7:1] zero
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [smask_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [smask_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [smask_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  smask_pkg::smask_cfg_t       cfg_r;
  smask_pkg::smask_cfg_t       cfg_nxt;
  smask_pkg::smask_reg_t       reg_idx;
  logic                        cfg_wr;

  logic                        s1_valid;
  smask_pkg::smask_s1_t        s1;
  logic [smask_pkg::LW-1:0]    luma_rd;
  logic                        s1_ready;
  logic                        s2_valid;
  smask_pkg::smask_s2_t        s2;

  logic                        adv;
  logic                        out_valid_r;
  logic                        covered_r;
  logic                        covered_nxt;
  logic                        iris_hit;
  logic                        tri_hit;
  logic [smask_pkg::TRI_PW-1:0] tri_lhs;
  logic [smask_pkg::TRI_PW-1:0] tri_rhs;

  // Config registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = smask_pkg::smask_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        smask_pkg::REG_MODE:    cfg_nxt.mode    = cfg_pwdata[smask_pkg::MODE_W-1:0];
        smask_pkg::REG_FOCUS_X: cfg_nxt.focus_x = cfg_pwdata[smask_pkg::XW-1:0];
        smask_pkg::REG_FOCUS_Y: cfg_nxt.focus_y = cfg_pwdata[smask_pkg::YW-1:0];
        smask_pkg::REG_IRIS_R:  cfg_nxt.iris_r  = cfg_pwdata[smask_pkg::IRIS_RW-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= smask_pkg::MODE_IRIS;
      cfg_r.focus_x <= smask_pkg::FOCUS_X_RST;
      cfg_r.focus_y <= smask_pkg::FOCUS_Y_RST;
      cfg_r.iris_r  <= smask_pkg::IRIS_R_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      smask_pkg::REG_MODE:    cfg_prdata = smask_pkg::CFG_DW'(cfg_r.mode);
      smask_pkg::REG_FOCUS_X: cfg_prdata = smask_pkg::CFG_DW'(cfg_r.focus_x);
      smask_pkg::REG_FOCUS_Y: cfg_prdata = smask_pkg::CFG_DW'(cfg_r.focus_y);
      smask_pkg::REG_IRIS_R:  cfg_prdata = smask_pkg::CFG_DW'(cfg_r.iris_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Stage 1: operand prep, luma table access
  smask_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_valid_i (in_tvalid),
    .in_write_i (in_tuser),
    .x_i        (in_tdata[7:0]),
    .y_i        (in_tdata[15:8]),
    .cov_i      (in_tdata[28:16]),
    .luma_i     (in_tdata[36:29]),
    .in_ready_o (in_tready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1),
    .luma_rd_o  (luma_rd),
    .s1_ready_i (s1_ready)
  );

  // Stage 2: squares, remainders, per-mode simple hits
  smask_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .luma_rd_i  (luma_rd),
    .s1_ready_o (s1_ready),
    .s2_valid_o (s2_valid),
    .s2_o       (s2),
    .s2_ready_i (adv)
  );

  // Stage 3: iris and tooth compares, mode select, output register
  assign adv = !out_valid_r || out_tready;

  assign iris_hit = {1'b0, s2.d2} >= s2.hole_sq;

  // x < floor(n*W/D)  <=>  (x+1)*D <= n*W
  assign tri_lhs = (smask_pkg::TRI_PW'(s2.x) + smask_pkg::TRI_PW'(1)) *
                   smask_pkg::TRI_PW'(smask_pkg::TRI_DENOM);
  assign tri_rhs = smask_pkg::TRI_PW'(s2.tri_n) * smask_pkg::TRI_PW'(smask_pkg::SCREEN_WIDTH);
  assign tri_hit = tri_lhs <= tri_rhs;

  always_comb begin
    unique case (smask_pkg::smask_mode_t'(cfg_r.mode))
      smask_pkg::MODE_IRIS:  covered_nxt = iris_hit;
      smask_pkg::MODE_TEETH: covered_nxt = tri_hit;
      default:               covered_nxt = s2.simple_hit;
    endcase
    if (s2.cov_zero) begin
      covered_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      covered_r <= covered_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, covered_r};

`ifndef SYNTH
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the pipeline has room");

  a_zero_cov_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_valid && s2.cov_zero |=> !out_tdata[0])
    else $error("zero coverage beat came out covered");
`endif

endmodule

[test/screen_transition_pixel_mask_tb.sv]
module screen_transition_pixel_mask_tb;

  // Run bounds
  localparam int unsigned RUN_LIMIT       = 200000;
  localparam int          PHASES          = 16;
  localparam int          BEATS_PER_PHASE = 80;
  localparam int          DRAIN_CYCLES    = 6;    // three stages plus margin
  localparam int          MAX_REPORTS     = 50;

  // Operation codes carried on in_tuser
  localparam bit OP_CLASSIFY   = 1'b0;
  localparam bit OP_LUMA_WRITE = 1'b1;

  // Mode value with no wipe behind it; every pixel must come out clear
  localparam logic [smask_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

  // 4x4 ordered-dither ranks, entry k in bits [4k+3:4k], k = (y&3)*4 + (x&3)
  localparam logic [63:0] DITHER_RANK = 64'h5D7F_91B3_6E4C_A280;

  // Expected-coverage tracker: mirrors the register file and the luma table,
  // computes the covered bit for every accepted classify beat and matches
  // result beats against those predictions in order.
  class mask_scoreboard;
    logic [smask_pkg::MODE_W-1:0]  mode_r = smask_pkg::MODE_IRIS;
    logic [smask_pkg::XW-1:0]      fx     = smask_pkg::FOCUS_X_RST;
    logic [smask_pkg::YW-1:0]      fy     = smask_pkg::FOCUS_Y_RST;
    logic [smask_pkg::IRIS_RW-1:0] radius = smask_pkg::IRIS_R_RST;
    logic [smask_pkg::LW-1:0]      luma_mem [smask_pkg::LUMA_DEPTH];
    bit                            expected_cover [$];
    int unsigned                   n_classify, n_writes, n_checked, n_errors;

    function void write_reg(smask_pkg::smask_reg_t idx, logic [smask_pkg::CFG_DW-1:0] val);
      case (idx)
        smask_pkg::REG_MODE:    mode_r = val[smask_pkg::MODE_W-1:0];
        smask_pkg::REG_FOCUS_X: fx     = val[smask_pkg::XW-1:0];
        smask_pkg::REG_FOCUS_Y: fy     = val[smask_pkg::YW-1:0];
        smask_pkg::REG_IRIS_R:  radius = val[smask_pkg::IRIS_RW-1:0];
        default: ;
      endcase
    endfunction

    function bit covered_at(logic [smask_pkg::XW-1:0] x, logic [smask_pkg::YW-1:0] y,
                            logic [smask_pkg::CW-1:0] cov);
      int     c, hole, dx, dy, lim, band, h, k, m, s;
      longint n;
      c = (cov > smask_pkg::FULL_COVER) ? smask_pkg::FULL_COVER : int'(cov);
      if (c == 0) return 1'b0;
      case (mode_r)
        smask_pkg::MODE_IRIS: begin
          hole = (int'(radius) * (smask_pkg::FULL_COVER - c)) >> smask_pkg::FRAC_W;
          dx   = int'(x) - int'(fx);
          dy   = int'(y) - int'(fy);
          return (dx * dx + dy * dy) >= hole * hole;
        end
        smask_pkg::MODE_WIPE: begin
          lim = (smask_pkg::SCREEN_WIDTH * c) >> smask_pkg::FRAC_W;
          return int'(x) < lim;
        end
        smask_pkg::MODE_CURTAIN: begin
          h = ((smask_pkg::SCREEN_HEIGHT / 2) * c) >> smask_pkg::FRAC_W;
          return int'(y) < h || int'(y) >= smask_pkg::SCREEN_HEIGHT - h;
        end
        smask_pkg::MODE_BLINDS: begin
          band = smask_pkg::SCREEN_HEIGHT / smask_pkg::BLIND_SLATS;
          if (band == 0) return 1'b0;
          h = (band * c) >> smask_pkg::FRAC_W;
          return int'(y) < smask_pkg::BLIND_SLATS * band && (int'(y) % band) < h;
        end
        smask_pkg::MODE_DISSOLVE: begin
          h = (16 * c + 2048) >> smask_pkg::FRAC_W;
          k = int'({y[1:0], x[1:0]});
          return int'(DITHER_RANK[4*k +: 4]) < h;
        end
        smask_pkg::MODE_LUMA: begin
          h = (255 * c) >> smask_pkg::FRAC_W;
          return int'(luma_mem[{y, x}]) < h;
        end
        smask_pkg::MODE_TEETH: begin
          // tooth height s in 1/40 of a period, n = 1.1*cov - 0.1*tooth
          m = int'(y) % smask_pkg::TOOTH_PERIOD;
          s = 2 * m - smask_pkg::TOOTH_PERIOD;
          if (s < 0) s = -s;
          s = smask_pkg::TOOTH_PERIOD - s;
          n = longint'(smask_pkg::TRI_A_MUL) * c - longint'(smask_pkg::FULL_COVER) * s;
          if (n < 0) n = 0;
          if (n > smask_pkg::TRI_DENOM) n = smask_pkg::TRI_DENOM;
          return longint'(x) < (n * smask_pkg::SCREEN_WIDTH) / smask_pkg::TRI_DENOM;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_beat(bit op, logic [smask_pkg::XW-1:0] x, logic [smask_pkg::YW-1:0] y,
                            logic [smask_pkg::CW-1:0] cov, logic [smask_pkg::LW-1:0] val);
      if (op == OP_LUMA_WRITE) begin
        luma_mem[{y, x}] = val;
        n_writes++;
      end else begin
        expected_cover.push_back(covered_at(x, y, cov));
        n_classify++;
      end
    endfunction

    function void check_beat(logic [7:0] data);
      bit want;
      if (expected_cover.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result beat with none expected, expected nothing actual covered=%b",
                   $time, data[0]);
        return;
      end
      want = expected_cover.pop_front();
      n_checked++;
      if (data[0] !== want) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: covered mismatch, expected %0b actual %b", $time, want, data[0]);
      end
    endfunction

    function int pending();
      return expected_cover.size();
    endfunction
  endclass

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  // [7:0] pixel_x, [15:8] pixel_y, [28:16] coverage, [36:29] luma_value, [39:37] zero
  logic [39:0]                  in_tdata    = '0;
  // [0] operation
  logic                         in_tuser    = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  // [0] covered, [7:1] zero
  logic [7:0]                   out_tdata;
  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [smask_pkg::CFG_AW-1:0] cfg_paddr   = '0;
  logic [smask_pkg::CFG_DW-1:0] cfg_pwdata  = '0;
  logic [smask_pkg::CFG_DW-1:0] cfg_prdata;
  logic                         cfg_pready;

  mask_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  int          stall_left  = 0;
  int          stall_style = 0;
  int          settings_run = 0;

  // Luma entries written so far; luma-mode queries only hit these
  bit          luma_seen [smask_pkg::LUMA_DEPTH];
  logic [15:0] luma_written_q [$];

  screen_transition_pixel_mask i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("** screen_transition_pixel_mask: FAILED **");
      $finish;
    end
  end

  // Result side: check accepted beats, then pick next ready.
  // Stall style, picked anew at random: always ready, light, heavy, 1-in-3.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
    if (stall_left == 0) begin
      stall_style = int'($urandom_range(0, 3));
      stall_left  = 48;
    end
    stall_left--;
    case (stall_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 9) < 4);
      default: out_tready <= (cycle_count % 3 == 0);
    endcase
  end

  // One APB write: setup then access. psel stays up so writes can chain;
  // program_regs drops the bus afterwards.
  task automatic cfg_write(smask_pkg::smask_reg_t idx, logic [smask_pkg::CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(logic [smask_pkg::MODE_W-1:0] md, logic [smask_pkg::XW-1:0] fx,
                              logic [smask_pkg::YW-1:0] fy,
                              logic [smask_pkg::IRIS_RW-1:0] r);
    cfg_write(smask_pkg::REG_MODE,    smask_pkg::CFG_DW'(md));
    cfg_write(smask_pkg::REG_FOCUS_X, smask_pkg::CFG_DW'(fx));
    cfg_write(smask_pkg::REG_FOCUS_Y, smask_pkg::CFG_DW'(fy));
    cfg_write(smask_pkg::REG_IRIS_R,  smask_pkg::CFG_DW'(r));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // Drop valid, wait for every expected beat, then let trailing table
  // writes clear the pipe before any register changes.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Present one beat and hold it until taken. Bursts of random length with
  // random gaps; some long bursts run with no gap at all.
  task automatic send_beat(bit op, logic [smask_pkg::XW-1:0] x, logic [smask_pkg::YW-1:0] y,
                           logic [smask_pkg::CW-1:0] cov, logic [smask_pkg::LW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, val, cov, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, x, y, cov, val);
    if (op == OP_LUMA_WRITE && !luma_seen[{y, x}]) begin
      luma_seen[{y, x}] = 1'b1;
      luma_written_q.push_back({y, x});
    end
  endtask

  // Random beat under the current mode. Coverage leans on the ends of its
  // range, including saturated values; iris queries often land near the focus.
  task automatic random_beat();
    bit                          op;
    logic [smask_pkg::XW-1:0]    x;
    logic [smask_pkg::YW-1:0]    y;
    logic [smask_pkg::CW-1:0]    cov;
    logic [smask_pkg::LW-1:0]    val;
    logic [15:0]                 idx;
    int                          pick;
    op   = ($urandom_range(0, 99) < 15) ? OP_LUMA_WRITE : OP_CLASSIFY;
    x    = smask_pkg::XW'($urandom_range(0, 255));
    y    = smask_pkg::YW'($urandom_range(0, 255));
    val  = smask_pkg::LW'($urandom_range(0, 255));
    pick = int'($urandom_range(0, 19));
    if (pick == 0)      cov = '0;
    else if (pick == 1) cov = smask_pkg::CW'(smask_pkg::FULL_COVER);
    else if (pick == 2) cov = smask_pkg::CW'($urandom_range(smask_pkg::FULL_COVER + 1, 8191));
    else                cov = smask_pkg::CW'($urandom_range(0, smask_pkg::FULL_COVER));
    if (op == OP_CLASSIFY && sb.mode_r == smask_pkg::MODE_IRIS &&
        $urandom_range(0, 3) == 0) begin
      x = sb.fx + smask_pkg::XW'($urandom_range(0, 40)) - smask_pkg::XW'(20);
      y = sb.fy + smask_pkg::YW'($urandom_range(0, 40)) - smask_pkg::YW'(20);
    end
    if (op == OP_CLASSIFY && sb.mode_r == smask_pkg::MODE_LUMA) begin
      // newest entry often, to hit a read right behind its write
      if ($urandom_range(0, 9) < 3) idx = luma_written_q[$];
      else idx = luma_written_q[$urandom_range(0, luma_written_q.size() - 1)];
      {y, x} = idx;
    end
    send_beat(op, x, y, cov, val);
  endtask

  initial begin
    logic [smask_pkg::MODE_W-1:0]  md;
    logic [smask_pkg::XW-1:0]      fx;
    logic [smask_pkg::YW-1:0]      fy;
    logic [smask_pkg::IRIS_RW-1:0] r;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: iris at (128,152), radius 200
    send_beat(OP_CLASSIFY, 8'd0,   8'd0,   13'd0,    8'hFF);  // zero coverage
    send_beat(OP_CLASSIFY, 8'd255, 8'd255, 13'd4096, 8'h00);  // full cover, hole gone
    send_beat(OP_CLASSIFY, 8'd128, 8'd152, 13'd2048, 8'h00);  // on the focus
    send_beat(OP_CLASSIFY, 8'd0,   8'd255, 13'd8191, 8'h00);  // saturated coverage
    send_beat(OP_CLASSIFY, 8'd255, 8'd0,   13'd1,    8'h00);  // smallest coverage
    // Table corners
    send_beat(OP_LUMA_WRITE, 8'd0,   8'd0,   13'd0,    8'h00);
    send_beat(OP_LUMA_WRITE, 8'd255, 8'd255, 13'd8191, 8'hFF);
    send_beat(OP_LUMA_WRITE, 8'd0,   8'd255, 13'd4096, 8'h80);
    send_beat(OP_LUMA_WRITE, 8'd255, 8'd0,   13'd1,    8'h7F);
    drain();

    // Unused mode: nothing gets covered
    program_regs(MODE_SPARE, 8'd128, 8'd152, 9'd200);
    send_beat(OP_CLASSIFY, 8'd255, 8'd255, 13'd4096, 8'h00);
    send_beat(OP_CLASSIFY, 8'd0,   8'd0,   13'd8191, 8'h00);
    drain();

    // Luma threshold against the corners just written
    program_regs(smask_pkg::MODE_LUMA, 8'd128, 8'd152, 9'd200);
    send_beat(OP_CLASSIFY, 8'd0,   8'd0,   13'd4096, 8'h00);
    send_beat(OP_CLASSIFY, 8'd255, 8'd255, 13'd4096, 8'h00);
    send_beat(OP_CLASSIFY, 8'd0,   8'd255, 13'd1,    8'h00);
    send_beat(OP_CLASSIFY, 8'd255, 8'd0,   13'd2048, 8'h00);
    send_beat(OP_CLASSIFY, 8'd255, 8'd255, 13'd8191, 8'h00);
    drain();

    // Random phases, one register setting each, cycling through all modes.
    // Two iris phases pin focus and radius at their extremes.
    for (int p = 0; p < PHASES; p++) begin
      md = smask_pkg::MODE_W'(p);
      if (p == 0) begin
        fx = 8'd0;   fy = 8'd0;   r = 9'd365;
      end else if (p == 8) begin
        fx = 8'd255; fy = 8'd255; r = 9'd0;
      end else begin
        fx = smask_pkg::XW'($urandom_range(0, 255));
        fy = smask_pkg::YW'($urandom_range(0, 255));
        r  = smask_pkg::IRIS_RW'($urandom_range(0, 365));
      end
      program_regs(md, fx, fy, r);
      repeat (BEATS_PER_PHASE) random_beat();
      drain();
    end

    $display("Covered %0d classify beats and %0d luma writes across %0d register settings,",
             sb.n_classify, sb.n_writes, settings_run);
    $display("all seven wipe modes plus the unused code; %0d result beats checked.",
             sb.n_checked);
    if (sb.n_errors == 0) begin
      $display("** screen_transition_pixel_mask: PASSED **");
    end else begin
      $display("** screen_transition_pixel_mask: FAILED **");
    end
    $finish;
  end

endmodule
